>>> rtl/core/ensemble_deviation_statistics_defines.svh
// ----------------------------------------------------------------------------
// ensemble_deviation_statistics_defines
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ENSEMBLE_DEVIATION_STATISTICS_DEFINES_SVH
`define ENSEMBLE_DEVIATION_STATISTICS_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define EDST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define EDST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/edst_pkg.sv
// ----------------------------------------------------------------------------
// edst_pkg
// Shared types and constants of the ensemble deviation statistics block.
// ----------------------------------------------------------------------------
package edst_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int MAX_MODELS_DEF = 8;
	localparam int MAX_ATOMS_DEF  = 65536;
	localparam int CFG_W          = 4;
	localparam int SUM_W          = 48;
	localparam int COUNT_W        = 17;
	localparam int DIV_STEP       = 8;
	localparam int NUM_FIELDS     = 4;

	localparam logic [1:0] FLD_X = 2'd0;
	localparam logic [1:0] FLD_Y = 2'd1;
	localparam logic [1:0] FLD_Z = 2'd2;
	localparam logic [1:0] FLD_E = 2'd3;

	typedef struct packed {
		logic valid;
		logic last;
	} edst_job_ctl_t;

	typedef struct packed {
		logic       job_pop;
		logic [1:0] rd_fld;
	} edst_rd_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0]      force_dev_sum;
		logic [VALUE_BITS-1:0] force_dev_max;
		logic [VALUE_BITS-1:0] force_dev_min;
		logic [SUM_W-1:0]      energy_dev_sum;
		logic [VALUE_BITS-1:0] energy_dev_max;
		logic [VALUE_BITS-1:0] energy_dev_min;
		logic [COUNT_W-1:0]    atom_count;
	} edst_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_SQ,
		ST_SQ_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_UPDATE
	} edst_state_t;

endpackage

>>> rtl/core/edst_div.sv
// ----------------------------------------------------------------------------
// edst_div
// Serial unsigned divider by a small divisor, DIV_STEP quotient bits a cycle.
// ----------------------------------------------------------------------------
module edst_div import edst_pkg::*; #(
	parameter int W  = 72,
	parameter int NW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [W-1:0]  quotient
);

	localparam int CNT  = W / DIV_STEP;
	localparam int CNTW = $clog2(CNT + 1);

	logic [W-1:0]    work_q, work_nxt;
	logic [NW-1:0]   rem_q, rem_nxt;
	logic [NW:0]     trial;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, done_q;

	// Restoring steps; quotient bits shift in from the bottom.
	always_comb begin
		rem_nxt  = rem_q;
		work_nxt = work_q;
		trial    = '0;
		for (int j = 0; j < DIV_STEP; j++) begin
			trial    = {rem_nxt, work_nxt[W-1]};
			work_nxt = {work_nxt[W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial       = trial - {1'b0, divisor};
				work_nxt[0] = 1'b1;
			end
			rem_nxt = trial[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(CNT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

>>> rtl/core/edst_sqrt.sv
// ----------------------------------------------------------------------------
// edst_sqrt
// Serial integer square root, one root bit a cycle, result floored.
// ----------------------------------------------------------------------------
module edst_sqrt import edst_pkg::*; #(
	parameter int W = VALUE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*W-1:0] radicand,
	output logic           done,
	output logic [W-1:0]   root
);

	localparam int CNTW = $clog2(W + 1);

	logic [2*W-1:0]  x_q;
	logic [W+1:0]    rem_q, rem_sh, trial;
	logic [W-1:0]    root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, done_q, ge;

	assign rem_sh = {rem_q[W-1:0], x_q[2*W-1:2*W-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[2*W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/core/edst_front.sv
// ----------------------------------------------------------------------------
// edst_front
// Takes model words, buffers them in two banks and sums each field per atom.
// ----------------------------------------------------------------------------
module edst_front import edst_pkg::*; #(
	parameter int MAX_MODELS = MAX_MODELS_DEF,
	localparam int IW = $clog2(MAX_MODELS),
	localparam int NW = $clog2(MAX_MODELS + 1),
	localparam int SW = VALUE_BITS + IW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                push,
	output logic                                full,
	input  logic signed [VALUE_BITS-1:0]        force_x,
	input  logic signed [VALUE_BITS-1:0]        force_y,
	input  logic signed [VALUE_BITS-1:0]        force_z,
	input  logic signed [VALUE_BITS-1:0]        energy,
	input  logic                                last_atom,
	input  edst_rd_ctl_t                        rd_ctl,
	input  logic [IW-1:0]                       rd_idx,
	output logic [VALUE_BITS-1:0]               rd_data,
	output edst_job_ctl_t                       job_ctl,
	output logic [NW-1:0]                       job_n,
	output logic [NUM_FIELDS-1:0][SW-1:0]       job_sum
);

	localparam int DEPTH = 2 ** (IW + 1);

	logic [CFG_W-1:0]                           num_models_q;
	logic [NW-1:0]                              n_eff;
	logic [IW-1:0]                              model_idx_q;
	logic                                       wr_bank_q, rd_bank_q;
	logic [1:0]                                 jobs_q;
	logic                                       accept, last_item;
	logic [NUM_FIELDS-1:0][VALUE_BITS-1:0]      in_word;
	logic [NUM_FIELDS-1:0][SW-1:0]              sum_q, sum_nxt;
	logic [NUM_FIELDS-1:0][VALUE_BITS-1:0]      buf_q [DEPTH];
	logic [NUM_FIELDS-1:0][SW-1:0]              job_sum_q [2];
	logic                                       job_last_q [2];
	logic [VALUE_BITS-1:0]                      rd_data_q;

	always_comb begin
		if (num_models_q < CFG_W'(2)) begin
			n_eff = NW'(2);
		end else if (32'(num_models_q) > MAX_MODELS) begin
			n_eff = NW'(MAX_MODELS);
		end else begin
			n_eff = NW'(num_models_q);
		end
	end

	assign full      = jobs_q == 2'd2;
	assign accept    = push && !full;
	assign last_item = (NW'(model_idx_q) + NW'(1)) == n_eff;
	assign in_word   = {energy, force_z, force_y, force_x};

	// Restart the sums on the first model of an atom.
	always_comb begin
		for (int f = 0; f < NUM_FIELDS; f++) begin
			sum_nxt[f] = (model_idx_q == '0 ? SW'(0) : sum_q[f])
				+ {{IW{in_word[f][VALUE_BITS-1]}}, in_word[f]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_models_q <= CFG_W'(2);
			model_idx_q  <= '0;
			wr_bank_q    <= 1'b0;
			rd_bank_q    <= 1'b0;
			jobs_q       <= '0;
		end else begin
			if (cfg_we) begin
				num_models_q <= cfg_wdata;
				model_idx_q  <= '0;
			end else if (accept) begin
				model_idx_q <= last_item ? '0 : model_idx_q + IW'(1);
			end
			if (accept && last_item) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (rd_ctl.job_pop) begin
				rd_bank_q <= !rd_bank_q;
			end
			jobs_q <= jobs_q + 2'(accept && last_item) - 2'(rd_ctl.job_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[{wr_bank_q, model_idx_q}] <= in_word;
			sum_q                           <= sum_nxt;
			if (last_item) begin
				job_sum_q[wr_bank_q]  <= sum_nxt;
				job_last_q[wr_bank_q] <= last_atom;
			end
		end
		rd_data_q <= buf_q[{rd_bank_q, rd_idx}][rd_ctl.rd_fld];
	end

	assign rd_data       = rd_data_q;
	assign job_ctl.valid = jobs_q != '0;
	assign job_ctl.last  = job_last_q[rd_bank_q];
	assign job_n         = n_eff;
	assign job_sum       = job_sum_q[rd_bank_q];

endmodule

>>> rtl/core/edst_back.sv
// ----------------------------------------------------------------------------
// edst_back
// Per atom: means, squared deviations, RMS; then frame sum, minimum, maximum.
// ----------------------------------------------------------------------------
module edst_back import edst_pkg::*; #(
	parameter int MAX_MODELS = MAX_MODELS_DEF,
	parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
	localparam int IW = $clog2(MAX_MODELS),
	localparam int NW = $clog2(MAX_MODELS + 1),
	localparam int SW = VALUE_BITS + IW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edst_job_ctl_t                 job_ctl,
	input  logic [NW-1:0]                 job_n,
	input  logic [NUM_FIELDS-1:0][SW-1:0] job_sum,
	input  logic [VALUE_BITS-1:0]         rd_data,
	output edst_rd_ctl_t                  rd_ctl,
	output logic [IW-1:0]                 rd_idx,
	output logic                          res_push,
	output edst_result_t                  res,
	input  logic                          res_ready
);

	localparam int VB    = VALUE_BITS;
	localparam int ACC_W = 2 * VB + $clog2(3 * MAX_MODELS);
	localparam int DIV_W = ((ACC_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int CW    = $clog2(MAX_ATOMS + 1);

	edst_state_t state_q, state_nxt;

	logic              div_start, div_done, sqrt_start, sqrt_done, issue, job_pop;
	logic [DIV_W-1:0]  div_in, div_quo;
	logic [VB-1:0]     root, dev;
	logic [1:0]        fld_q, fld_s1;
	logic [IW-1:0]     idx_q;
	logic              eng_q, eng_s2, valid_s1, valid_s2, sat_q;
	logic [VB-1:0]     mean_q [NUM_FIELDS];
	logic [SW-1:0]     sum_sel, sum_mag;
	logic [VB-1:0]     mean_sel;
	logic [VB:0]       diff, diff_mag;
	logic [2*VB-1:0]   prod_s2;
	logic [ACC_W-1:0]  facc_q, eacc_q;
	logic [VB-1:0]     fdev_q, edev_q;
	logic [SUM_W-1:0]  force_total_q, energy_total_q, ft_new, et_new;
	logic [SUM_W:0]    ft_add, et_add;
	logic [VB-1:0]     force_high_q, force_low_q, energy_high_q, energy_low_q;
	logic [VB-1:0]     fh_new, fl_new, eh_new, el_new;
	logic [CW-1:0]     atoms_q, atoms_new;

	edst_div #(.W(DIV_W), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (job_n),
		.done     (div_done),
		.quotient (div_quo)
	);

	edst_sqrt #(.W(VB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo[2*VB-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	assign sum_sel = job_sum[fld_q];
	assign sum_mag = sum_sel[SW-1] ? SW'(0) - sum_sel : sum_sel;

	always_comb begin
		if (state_q == ST_MEAN_GO) begin
			div_in = DIV_W'(sum_mag);
		end else begin
			div_in = DIV_W'(eng_q ? eacc_q : facc_q);
		end
	end

	always_comb begin
		state_nxt  = state_q;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		issue      = 1'b0;
		job_pop    = 1'b0;
		res_push   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_ctl.valid) state_nxt = ST_MEAN_GO;
			end
			ST_MEAN_GO: begin
				div_start = 1'b1;
				state_nxt = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (div_done) state_nxt = (fld_q == FLD_E) ? ST_SQ : ST_MEAN_GO;
			end
			ST_SQ: begin
				issue = 1'b1;
				if (NW'(idx_q) + NW'(1) == job_n && fld_q == FLD_E) state_nxt = ST_SQ_DRAIN;
			end
			ST_SQ_DRAIN: begin
				if (!valid_s1 && !valid_s2) state_nxt = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_nxt = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) state_nxt = ST_ROOT_GO;
			end
			ST_ROOT_GO: begin
				sqrt_start = 1'b1;
				state_nxt  = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (sqrt_done) state_nxt = eng_q ? ST_UPDATE : ST_DIV_GO;
			end
			ST_UPDATE: begin
				// Hold while a finished frame still waits at the output.
				if (!job_ctl.last || res_ready) begin
					job_pop   = 1'b1;
					res_push  = job_ctl.last;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign mean_sel = mean_q[fld_s1];
	assign diff     = {rd_data[VB-1], rd_data} - {mean_sel[VB-1], mean_sel};
	assign diff_mag = diff[VB] ? (VB+1)'(0) - diff : diff;
	assign dev      = sat_q ? '1 : root;

	assign ft_add    = {1'b0, force_total_q} + (SUM_W+1)'(fdev_q);
	assign et_add    = {1'b0, energy_total_q} + (SUM_W+1)'(edev_q);
	assign ft_new    = ft_add[SUM_W] ? '1 : ft_add[SUM_W-1:0];
	assign et_new    = et_add[SUM_W] ? '1 : et_add[SUM_W-1:0];
	assign fh_new    = (fdev_q > force_high_q) ? fdev_q : force_high_q;
	assign fl_new    = (fdev_q < force_low_q) ? fdev_q : force_low_q;
	assign eh_new    = (edev_q > energy_high_q) ? edev_q : energy_high_q;
	assign el_new    = (edev_q < energy_low_q) ? edev_q : energy_low_q;
	assign atoms_new = (atoms_q < CW'(MAX_ATOMS)) ? atoms_q + CW'(1) : atoms_q;

	assign res.force_dev_sum  = ft_new;
	assign res.force_dev_max  = fh_new;
	assign res.force_dev_min  = fl_new;
	assign res.energy_dev_sum = et_new;
	assign res.energy_dev_max = eh_new;
	assign res.energy_dev_min = el_new;
	assign res.atom_count     = COUNT_W'({{COUNT_W{1'b0}}, atoms_new});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			force_total_q  <= '0;
			energy_total_q <= '0;
			force_high_q   <= '0;
			energy_high_q  <= '0;
			force_low_q    <= '1;
			energy_low_q   <= '1;
			atoms_q        <= '0;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (res_push) begin
				force_total_q  <= '0;
				energy_total_q <= '0;
				force_high_q   <= '0;
				energy_high_q  <= '0;
				force_low_q    <= '1;
				energy_low_q   <= '1;
				atoms_q        <= '0;
			end else if (job_pop) begin
				force_total_q  <= ft_new;
				energy_total_q <= et_new;
				force_high_q   <= fh_new;
				energy_high_q  <= eh_new;
				force_low_q    <= fl_new;
				energy_low_q   <= el_new;
				atoms_q        <= atoms_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		fld_s1  <= fld_q;
		eng_s2  <= fld_s1 == FLD_E;
		prod_s2 <= diff_mag[VB-1:0] * diff_mag[VB-1:0];
		if (state_q == ST_IDLE) begin
			fld_q  <= FLD_X;
			idx_q  <= '0;
			eng_q  <= 1'b0;
			facc_q <= '0;
			eacc_q <= '0;
		end else begin
			if (state_q == ST_MEAN_WAIT && div_done) begin
				mean_q[fld_q] <= sum_sel[SW-1] ? VB'(0) - div_quo[VB-1:0] : div_quo[VB-1:0];
				fld_q         <= fld_q + 2'd1;
			end
			if (issue) begin
				fld_q <= fld_q + 2'd1;
				if (fld_q == FLD_E) idx_q <= idx_q + IW'(1);
			end
			if (valid_s2) begin
				if (eng_s2) eacc_q <= eacc_q + ACC_W'(prod_s2);
				else        facc_q <= facc_q + ACC_W'(prod_s2);
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				sat_q <= |div_quo[DIV_W-1:2*VB];
			end
			if (state_q == ST_ROOT_WAIT && sqrt_done) begin
				if (eng_q) edev_q <= dev;
				else       fdev_q <= dev;
				eng_q <= 1'b1;
			end
		end
	end

	assign rd_ctl.job_pop = job_pop;
	assign rd_ctl.rd_fld  = fld_q;
	assign rd_idx         = idx_q;

endmodule

>>> rtl/core/ensemble_deviation_statistics.sv
// ----------------------------------------------------------------------------
// ensemble_deviation_statistics
// Committee-model force and energy deviation, summed and bounded per frame.
// ----------------------------------------------------------------------------
// Input channel: one word per (atom, model), written with push while full is
// low. num_models consecutive words (clamped to 2..MAX_MODELS) make one atom.
// The front takes one word a cycle, while full is low, into one of two buffer
// banks, so words of the next atom flow in while the previous atom is worked
// on; full rises when both banks hold atoms. For each atom the back end makes
// six passes through the serial divider, two square roots, one buffer read
// per field and model, and then the pipeline drain and bookkeeping.
// Result channel: a word appears (empty low) after the last model of an atom
// flagged last_atom is processed; take it with pop. One result waits in the
// output register; if it is not taken, the back end holds at its next frame
// end and the front fills up and raises full.
// cfg_we writes num_models and drops any partial atom; write it only when
// idle. Reset empties both channels, sets num_models to 2, clears the frame.
// ----------------------------------------------------------------------------
`include "ensemble_deviation_statistics_defines.svh"

module ensemble_deviation_statistics import edst_pkg::*; #(
	parameter int MAX_MODELS = MAX_MODELS_DEF,
	parameter int MAX_ATOMS  = MAX_ATOMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_W-1:0]             cfg_wdata,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] force_x,
	input  logic signed [VALUE_BITS-1:0] force_y,
	input  logic signed [VALUE_BITS-1:0] force_z,
	input  logic signed [VALUE_BITS-1:0] energy,
	input  logic                         last_atom,
	output logic                         empty,
	input  logic                         pop,
	output logic [SUM_W-1:0]             force_dev_sum,
	output logic [VALUE_BITS-1:0]        force_dev_max,
	output logic [VALUE_BITS-1:0]        force_dev_min,
	output logic [SUM_W-1:0]             energy_dev_sum,
	output logic [VALUE_BITS-1:0]        energy_dev_max,
	output logic [VALUE_BITS-1:0]        energy_dev_min,
	output logic [COUNT_W-1:0]           atom_count
);

	localparam int IW = $clog2(MAX_MODELS);
	localparam int NW = $clog2(MAX_MODELS + 1);
	localparam int SW = VALUE_BITS + IW;

	edst_rd_ctl_t                  rd_ctl;
	edst_job_ctl_t                 job_ctl;
	logic [IW-1:0]                 rd_idx;
	logic [VALUE_BITS-1:0]         rd_data;
	logic [NW-1:0]                 job_n;
	logic [NUM_FIELDS-1:0][SW-1:0] job_sum;
	logic                          res_push, res_ready;
	edst_result_t                  res, out_q;
	logic                          out_valid_q;

	edst_front #(.MAX_MODELS(MAX_MODELS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.force_x   (force_x),
		.force_y   (force_y),
		.force_z   (force_z),
		.energy    (energy),
		.last_atom (last_atom),
		.rd_ctl    (rd_ctl),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.job_ctl   (job_ctl),
		.job_n     (job_n),
		.job_sum   (job_sum)
	);

	edst_back #(.MAX_MODELS(MAX_MODELS), .MAX_ATOMS(MAX_ATOMS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_ctl   (job_ctl),
		.job_n     (job_n),
		.job_sum   (job_sum),
		.rd_data   (rd_data),
		.rd_ctl    (rd_ctl),
		.rd_idx    (rd_idx),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_q <= res;
	end

	assign empty          = !out_valid_q;
	assign force_dev_sum  = out_q.force_dev_sum;
	assign force_dev_max  = out_q.force_dev_max;
	assign force_dev_min  = out_q.force_dev_min;
	assign energy_dev_sum = out_q.energy_dev_sum;
	assign energy_dev_max = out_q.energy_dev_max;
	assign energy_dev_min = out_q.energy_dev_min;
	assign atom_count     = out_q.atom_count;

	`EDST_ASSERT_NOW(a_pop_needs_job, clk, arst_n, rd_ctl.job_pop, job_ctl.valid)
	`EDST_ASSERT_NOW(a_push_needs_room, clk, arst_n, res_push, !out_valid_q || pop)
	`EDST_ASSERT_NEXT(a_push_fills, clk, arst_n, res_push, !empty)
	`EDST_ASSERT_NOW(a_frame_has_atoms, clk, arst_n, !empty, atom_count != '0)

endmodule
